// ===== rtl/msi_pkg.sv =====
// Shared types, codes and helpers of the motion setpoint interpolator.
`default_nettype none
package msi_pkg;

	localparam int ACC_W = 100;

	localparam logic [2:0] REQ_POS    = 3'd0;
	localparam logic [2:0] REQ_VEL    = 3'd1;
	localparam logic [2:0] REQ_TORQUE = 3'd2;
	localparam logic [2:0] REQ_TRAJ   = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;

	localparam logic CFG_VLIM = 1'b0;
	localparam logic CFG_ALIM = 1'b1;

	typedef enum logic [1:0] {
		MODE_POS    = 2'd0,
		MODE_VEL    = 2'd1,
		MODE_TORQUE = 2'd2,
		MODE_TRAJ   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] set_pos;
		logic signed [31:0] set_vel;
		logic signed [31:0] set_acc;
		logic signed [31:0] set_torque;
		logic signed [31:0] meas_pos;
		logic signed [31:0] meas_vel;
		logic [15:0]        step_time;
		logic [31:0]        time_now;
	} req_t;

	typedef struct packed {
		logic               pos_ctrl_en;
		logic               vel_ctrl_en;
		logic signed [31:0] pos_setpoint;
		logic signed [31:0] vel_setpoint;
		logic signed [31:0] ff_torque;
	} res_t;

	// Clamp a wide signed value to the signed 32 bit range.
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(32'sh7fffffff);
		lo = ACC_W'(-32'sh7fffffff - 32'sd1);
		if (v > hi) return 32'sh7fffffff;
		else if (v < lo) return -32'sh7fffffff - 32'sd1;
		else return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/msi_chan_if.sv =====
// Valid/ready channels for request and result beats.
`default_nettype none
interface msi_req_if;
	logic          valid;
	logic          ready;
	msi_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface msi_res_if;
	logic          valid;
	logic          ready;
	msi_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/msi_mul.sv =====
// Shared registered 33x33 signed multiplier.
`default_nettype none
module msi_mul (
	input  wire logic               clk,
	input  wire logic signed [32:0] a,
	input  wire logic signed [32:0] b,
	output logic signed [65:0]      prod_s1
);
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end
endmodule
`default_nettype wire

// ===== rtl/msi_core.sv =====
// Sequencer, mode state and wide accumulator around the shared multiplier.
`default_nettype none
module msi_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire msi_pkg::req_t in_data,
	input  wire logic [30:0]   vlim,
	input  wire logic [30:0]   alim,
	input  wire logic          res_free,
	output logic               res_push,
	output msi_pkg::res_t      res_data
);
	localparam int ACC_W  = msi_pkg::ACC_W;
	localparam int SH_POS = 2 * FRAC_BITS + 1;
	localparam int SH_VEL = FRAC_BITS + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_PR0, S_PR1, S_PR2, S_PR3, S_PR4, S_RD, S_RM1, S_RM2, S_RM3,
		S_RM4, S_RDEC, S_FIN, S_V0, S_V1, S_V2, S_DONE
	} state_t;

	state_t                  state_q;
	msi_pkg::mode_t          mode_q;
	logic signed [31:0]      sp_pos_q, sp_vel_q, goal_pos_q, goal_vel_q;
	logic signed [31:0]      sp_torque_q, path_acc_q;
	logic [31:0]             start_q, t_q;
	logic [15:0]             dt_q;
	logic                    pass_q;
	logic signed [32:0]      a_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [65:0]      p_q;
	logic signed [63:0]      d_q;
	logic [63:0]             mag_q;
	logic [47:0]             lim_q;
	msi_pkg::res_t           res_q;

	logic signed [32:0]      mul_a, mul_b;
	logic signed [65:0]      prod_s1;
	logic [31:0]             vmag;
	logic signed [32:0]      lim33, a_next;
	logic signed [ACC_W-1:0] err, vsum;
	logic signed [32:0]      delta;
	logic signed [48:0]      dl, lm, dsel;
	logic signed [31:0]      pos_o, vel_o;
	logic                    accept;

	msi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_s1(prod_s1));

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign res_push = (state_q == S_DONE) && res_free;
	assign res_data = res_q;

	assign vmag  = sp_vel_q[31] ? 32'(-sp_vel_q) : 32'(sp_vel_q);
	assign lim33 = $signed({2'b00, alim});
	assign err   = (ACC_W'(goal_pos_q) <<< SH_POS) - acc_q;
	assign vsum  = (ACC_W'(sp_vel_q) <<< FRAC_BITS) + ACC_W'(p_q);
	assign pos_o = msi_pkg::sat32(acc_q >>> SH_POS);
	assign vel_o = msi_pkg::sat32(vsum >>> FRAC_BITS);
	assign delta = 33'(goal_vel_q) - 33'(sp_vel_q);
	assign dl    = 49'(delta);
	assign lm    = $signed({1'b0, lim_q});

	always_comb begin
		if (dl > lm) dsel = lm;
		else if (dl < -lm) dsel = -lm;
		else dsel = dl;
	end

	// Ramp decision: brake when the accumulator (v^2 - |d|*2L) is not negative.
	always_comb begin
		if (d_q[63] == sp_vel_q[31]) begin
			if (!acc_q[ACC_W-1]) a_next = d_q[63] ? lim33 : -lim33;
			else if (vmag >= {1'b0, vlim}) a_next = '0;
			else a_next = d_q[63] ? -lim33 : lim33;
		end else begin
			a_next = d_q[63] ? -lim33 : lim33;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_PR0: begin mul_a = a_q; mul_b = $signed({1'b0, t_q}); end
			S_PR1: begin mul_a = 33'(sp_vel_q); mul_b = $signed({1'b0, t_q}); end
			S_PR2: begin mul_a = $signed({1'b0, p_q[31:0]}); mul_b = $signed({1'b0, t_q}); end
			S_PR3: begin mul_a = p_q[64:32]; mul_b = $signed({1'b0, t_q}); end
			S_RD:  begin mul_a = $signed({1'b0, vmag}); mul_b = $signed({1'b0, vmag}); end
			S_RM2: begin
				mul_a = $signed({1'b0, mag_q[31:0]});
				mul_b = $signed({1'b0, alim, 1'b0});
			end
			S_RM3: begin
				mul_a = $signed({1'b0, mag_q[63:32]});
				mul_b = $signed({1'b0, alim, 1'b0});
			end
			S_V0:  begin mul_a = $signed({17'd0, dt_q}); mul_b = $signed({2'b00, alim}); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= msi_pkg::MODE_TORQUE;
			sp_pos_q    <= '0;
			sp_vel_q    <= '0;
			goal_pos_q  <= '0;
			goal_vel_q  <= '0;
			sp_torque_q <= '0;
			path_acc_q  <= '0;
			start_q     <= '0;
			pass_q      <= 1'b0;
			dt_q        <= '0;
			t_q         <= '0;
			a_q         <= '0;
			acc_q       <= '0;
			p_q         <= '0;
			d_q         <= '0;
			mag_q       <= '0;
			lim_q       <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) begin
					case (in_data.req_type)
						msi_pkg::REQ_POS: begin
							if (mode_q == msi_pkg::MODE_TORQUE) begin
								sp_pos_q <= in_data.meas_pos;
								sp_vel_q <= in_data.meas_vel;
							end
							if (mode_q == msi_pkg::MODE_VEL) sp_pos_q <= in_data.meas_pos;
							mode_q     <= msi_pkg::MODE_POS;
							goal_pos_q <= in_data.set_pos;
						end
						msi_pkg::REQ_VEL: begin
							if (mode_q == msi_pkg::MODE_TORQUE) sp_vel_q <= in_data.meas_vel;
							mode_q     <= msi_pkg::MODE_VEL;
							goal_vel_q <= in_data.set_vel;
						end
						msi_pkg::REQ_TORQUE: begin
							mode_q      <= msi_pkg::MODE_TORQUE;
							sp_torque_q <= in_data.set_torque;
						end
						msi_pkg::REQ_TRAJ: begin
							mode_q      <= msi_pkg::MODE_TRAJ;
							sp_pos_q    <= in_data.set_pos;
							sp_vel_q    <= in_data.set_vel;
							path_acc_q  <= in_data.set_acc;
							sp_torque_q <= in_data.set_torque;
							start_q     <= in_data.time_now;
						end
						msi_pkg::REQ_TICK: begin
							dt_q <= in_data.step_time;
							unique case (mode_q)
								msi_pkg::MODE_TRAJ: begin
									t_q     <= in_data.time_now - start_q;
									a_q     <= 33'(path_acc_q);
									pass_q  <= 1'b1;
									state_q <= S_PR0;
								end
								msi_pkg::MODE_POS: begin
									t_q     <= 32'(in_data.step_time);
									a_q     <= lim33;
									pass_q  <= 1'b0;
									state_q <= S_PR0;
								end
								msi_pkg::MODE_VEL: state_q <= S_V0;
								default: begin
									res_q   <= '{1'b0, 1'b0, 32'sd0, 32'sd0, sp_torque_q};
									state_q <= S_DONE;
								end
							endcase
						end
						default: ;
					endcase
				end
				S_PR0: begin
					acc_q   <= ACC_W'(sp_pos_q) <<< SH_POS;
					state_q <= S_PR1;
				end
				S_PR1: begin
					p_q     <= prod_s1;
					state_q <= S_PR2;
				end
				S_PR2: begin
					acc_q   <= acc_q + (ACC_W'(prod_s1) <<< SH_VEL);
					state_q <= S_PR3;
				end
				S_PR3: begin
					acc_q   <= acc_q + ACC_W'(prod_s1);
					state_q <= S_PR4;
				end
				S_PR4: begin
					acc_q   <= acc_q + (ACC_W'(prod_s1) <<< 32);
					state_q <= pass_q ? S_FIN : S_RD;
				end
				S_RD: begin
					d_q     <= 64'(err >>> SH_VEL);
					state_q <= S_RM1;
				end
				S_RM1: begin
					acc_q   <= ACC_W'(prod_s1);
					mag_q   <= d_q[63] ? 64'(-d_q) : 64'(d_q);
					state_q <= S_RM2;
				end
				S_RM2: state_q <= S_RM3;
				S_RM3: begin
					acc_q   <= acc_q - ACC_W'(prod_s1);
					state_q <= S_RM4;
				end
				S_RM4: begin
					acc_q   <= acc_q - (ACC_W'(prod_s1) <<< 32);
					state_q <= S_RDEC;
				end
				S_RDEC: begin
					a_q     <= a_next;
					pass_q  <= 1'b1;
					state_q <= S_PR0;
				end
				S_FIN: begin
					if (mode_q == msi_pkg::MODE_POS) begin
						sp_pos_q <= pos_o;
						sp_vel_q <= vel_o;
						res_q    <= '{1'b1, 1'b1, pos_o, vel_o, 32'sd0};
					end else begin
						res_q    <= '{1'b1, 1'b1, pos_o, vel_o, sp_torque_q};
					end
					state_q <= S_DONE;
				end
				S_V0: state_q <= S_V1;
				S_V1: begin
					lim_q   <= 48'(prod_s1 >>> FRAC_BITS);
					state_q <= S_V2;
				end
				S_V2: begin
					sp_vel_q <= sp_vel_q + dsel[31:0];
					res_q    <= '{1'b0, 1'b1, 32'sd0, sp_vel_q + dsel[31:0], 32'sd0};
					state_q  <= S_DONE;
				end
				S_DONE: if (res_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_mode_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(mode_q))
		else $error("mode changed during a tick");
	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.req_type != msi_pkg::REQ_TICK) |=> (state_q == S_IDLE))
		else $error("command did not complete in one cycle");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_free && state_q == S_DONE))
		else $error("result pushed into a full output slot");
	a_ramp_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDEC) |=> (state_q == S_PR0 && pass_q))
		else $error("ramp decision not followed by the move pass");
endmodule
`default_nettype wire

// ===== rtl/motion_setpoint_interpolator_top.sv =====
// Top level of the motion setpoint interpolator: config registers and result register.
// Usage:
//   req carries command and tick beats (valid/ready). Commands (set position,
//   velocity, torque, trajectory) update the mode and targets and produce no
//   result. A tick beat produces one beat on res with the loop enables, the
//   position and velocity setpoints and the feedforward torque.
//   Config writes (cfg_we, cfg_idx, cfg_wdata) set the velocity limit (index 0)
//   and the acceleration limit (index 1); issue them only while the block is idle.
// Sequencing:
//   A command is taken while idle and leaves the block idle. A tick in torque
//   mode goes straight to the result; velocity mode forms the slew limit;
//   trajectory mode runs one prediction pass; position mode runs a prediction
//   pass, the ramp decision and a second pass. All wide products go through
//   one shared registered 33x33 multiplier, with the sequencer issuing one
//   partial product at a time. req is ready only while no tick is in progress.
// Reset:
//   arst_n clears the mode to torque, all setpoints and targets to zero and
//   both limits to 1.0. The result register holds one beat; when the receiver
//   stalls, a finished tick waits there, while new commands are still taken.
`default_nettype none
module motion_setpoint_interpolator_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	msi_req_if.sink          req,
	msi_res_if.source        res,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [30:0] cfg_wdata
);
	logic [30:0]   vlim_q, alim_q;
	logic          res_valid_q;
	msi_pkg::res_t res_data_q;
	logic          res_free, res_push;
	msi_pkg::res_t core_res;

	// Hold the limits; a write lands at the edge with cfg_we high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlim_q <= 31'd65536;
			alim_q <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				msi_pkg::CFG_VLIM: vlim_q <= cfg_wdata;
				msi_pkg::CFG_ALIM: alim_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The output slot is free when empty or being drained this cycle.
	assign res_free = !res_valid_q || res.ready;

	msi_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_data  (req.data),
		.vlim     (vlim_q),
		.alim     (alim_q),
		.res_free (res_free),
		.res_push (res_push),
		.res_data (core_res)
	);

	// Result register: load on push, drop the beat once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_push) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) res_data_q <= core_res;
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;
endmodule
`default_nettype wire

// ===== sim/tb_motion_setpoint_interpolator_top.sv =====
// Self-checking testbench of the motion setpoint interpolator: random and directed beats.
`timescale 1ns / 1ps
module tb_motion_setpoint_interpolator_top;

	typedef logic signed [127:0] wide_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 30;
	localparam logic [2:0] REQ_LAST = 3'd7;
	localparam logic [30:0] LIM_MAX = 31'h7fffffff;
	localparam logic [30:0] LIM_ONE = 31'd65536;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [30:0] cfg_wdata;

	msi_req_if req_ch();
	msi_res_if res_ch();

	motion_setpoint_interpolator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow state of the setpoint generator.
	msi_pkg::mode_t sh_mode;
	logic [31:0] sh_sp_pos, sh_sp_vel, sh_goal_pos, sh_goal_vel;
	logic [31:0] sh_torque, sh_path_acc, sh_start_time;
	logic [30:0] sh_vlim, sh_alim;

	msi_pkg::res_t expected_setpts[$];
	int   mismatches = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles = 0;
	logic [31:0] clock_q = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// --------------------------------------------------------------------
	// Wide fixed-point helpers: every product is held exactly in 128 bits.
	// --------------------------------------------------------------------
	function automatic wide_t widen(input logic [31:0] v);
		wide_t w;
		w = {{96{v[31]}}, v};
		return w;
	endfunction

	function automatic logic [31:0] clamp32(input wide_t v);
		wide_t hi, lo;
		hi = {97'b0, {31{1'b1}}};
		lo = {{97{1'b1}}, 31'b0};
		if (v > hi) return 32'h7fffffff;
		if (v < lo) return 32'h80000000;
		return v[31:0];
	endfunction

	// pos + vel*t + acc*t*t/2, scaled by 2^33
	function automatic wide_t extrapolate(input wide_t pos, input wide_t vel, input wide_t acc,
			input logic [31:0] t);
		wide_t tw;
		tw = {96'b0, t};
		return (pos <<< 33) + ((vel * tw) <<< 17) + acc * tw * tw;
	endfunction

	task automatic advance(input wide_t pos, input wide_t vel, input wide_t acc,
			input logic [31:0] t, output logic [31:0] pos_out, output logic [31:0] vel_out);
		wide_t tw;
		tw = {96'b0, t};
		pos_out = clamp32(extrapolate(pos, vel, acc, t) >>> 33);
		vel_out = clamp32(((vel <<< 16) + acc * tw) >>> 16);
	endtask

	// Bang-bang ramp: brake, cruise or accelerate toward the goal position.
	function automatic wide_t ramp_accel(input logic [15:0] dt);
		wide_t lim, vel, e, d, mag, vmag, brake;
		bit goal_ahead, moving_fwd;
		lim = {97'b0, sh_alim};
		vel = widen(sh_sp_vel);
		e = (widen(sh_goal_pos) <<< 33) - extrapolate(widen(sh_sp_pos), vel, lim, {16'b0, dt});
		d = e >>> 17;
		mag = (d < 0) ? -d : d;
		vmag = (vel < 0) ? -vel : vel;
		goal_ahead = (d >= 0);
		moving_fwd = (vel >= 0);
		if (sh_alim == 0) brake = {1'b0, {127{1'b1}}};
		else brake = (vmag * vmag) / (2 * lim);
		if (goal_ahead == moving_fwd) begin
			if (mag <= brake) return goal_ahead ? -lim : lim;
			if (vmag >= {97'b0, sh_vlim}) return 0;
		end
		return goal_ahead ? lim : -lim;
	endfunction

	// Update the shadow state for one accepted beat; queue a result for a tick.
	task automatic predict_beat(input msi_pkg::req_t r);
		msi_pkg::res_t o;
		wide_t step, delta;
		logic [31:0] p, v;
		o = '0;
		case (r.req_type)
			msi_pkg::REQ_POS: begin
				if (sh_mode == msi_pkg::MODE_TORQUE) begin
					sh_sp_pos = r.meas_pos;
					sh_sp_vel = r.meas_vel;
				end
				if (sh_mode == msi_pkg::MODE_VEL) sh_sp_pos = r.meas_pos;
				sh_mode = msi_pkg::MODE_POS;
				sh_goal_pos = r.set_pos;
			end
			msi_pkg::REQ_VEL: begin
				if (sh_mode == msi_pkg::MODE_TORQUE) sh_sp_vel = r.meas_vel;
				sh_mode = msi_pkg::MODE_VEL;
				sh_goal_vel = r.set_vel;
			end
			msi_pkg::REQ_TORQUE: begin
				sh_mode = msi_pkg::MODE_TORQUE;
				sh_torque = r.set_torque;
			end
			msi_pkg::REQ_TRAJ: begin
				sh_mode = msi_pkg::MODE_TRAJ;
				sh_sp_pos = r.set_pos;
				sh_sp_vel = r.set_vel;
				sh_path_acc = r.set_acc;
				sh_torque = r.set_torque;
				sh_start_time = r.time_now;
			end
			msi_pkg::REQ_TICK: begin
				case (sh_mode)
					msi_pkg::MODE_TRAJ: begin
						advance(widen(sh_sp_pos), widen(sh_sp_vel), widen(sh_path_acc),
							r.time_now - sh_start_time, p, v);
						o.pos_ctrl_en = 1'b1;
						o.vel_ctrl_en = 1'b1;
						o.pos_setpoint = p;
						o.vel_setpoint = v;
						o.ff_torque = sh_torque;
					end
					msi_pkg::MODE_TORQUE: o.ff_torque = sh_torque;
					msi_pkg::MODE_VEL: begin
						step = ({112'b0, r.step_time} * {97'b0, sh_alim}) >>> 16;
						delta = widen(sh_goal_vel) - widen(sh_sp_vel);
						if (delta > step) delta = step;
						if (delta < -step) delta = -step;
						sh_sp_vel = sh_sp_vel + delta[31:0];
						o.vel_ctrl_en = 1'b1;
						o.vel_setpoint = sh_sp_vel;
					end
					default: begin
						advance(widen(sh_sp_pos), widen(sh_sp_vel), ramp_accel(r.step_time),
							{16'b0, r.step_time}, p, v);
						sh_sp_pos = p;
						sh_sp_vel = v;
						o.pos_ctrl_en = 1'b1;
						o.vel_ctrl_en = 1'b1;
						o.pos_setpoint = p;
						o.vel_setpoint = v;
					end
				endcase
				expected_setpts.push_back(o);
			end
			default: ; // unused request codes are dropped by the block
		endcase
	endtask

	// --------------------------------------------------------------------
	// Result side: random stall, compare each beat, watchdog on silence.
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		msi_pkg::res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_setpts.size() == 0) begin
					$error("result beat with no tick waiting");
					mismatches++;
				end else begin
					want = expected_setpts.pop_front();
					if (res_ch.data.pos_ctrl_en !== want.pos_ctrl_en) begin
						$error("pos_ctrl_en exp %0d got %0d", want.pos_ctrl_en,
							res_ch.data.pos_ctrl_en);
						mismatches++;
					end
					if (res_ch.data.vel_ctrl_en !== want.vel_ctrl_en) begin
						$error("vel_ctrl_en exp %0d got %0d", want.vel_ctrl_en,
							res_ch.data.vel_ctrl_en);
						mismatches++;
					end
					if (res_ch.data.pos_setpoint !== want.pos_setpoint) begin
						$error("pos_setpoint exp %0d got %0d", want.pos_setpoint,
							res_ch.data.pos_setpoint);
						mismatches++;
					end
					if (res_ch.data.vel_setpoint !== want.vel_setpoint) begin
						$error("vel_setpoint exp %0d got %0d", want.vel_setpoint,
							res_ch.data.vel_setpoint);
						mismatches++;
					end
					if (res_ch.data.ff_torque !== want.ff_torque) begin
						$error("ff_torque exp %0d got %0d", want.ff_torque,
							res_ch.data.ff_torque);
						mismatches++;
					end
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			// count cycles in which no beat moves on either channel
			if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// --------------------------------------------------------------------
	// Request side
	// --------------------------------------------------------------------
	// Drive one beat, hold it until taken, then predict. Valid stays high.
	task automatic send_beat(input msi_pkg::req_t item);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		do @(posedge clk); while (!req_ch.ready);
		predict_beat(item);
	endtask

	// Hold off until every queued tick has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_setpts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [30:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == msi_pkg::CFG_VLIM) sh_vlim = value;
		else sh_alim = value;
	endtask

	task automatic set_limits(input logic [30:0] vlim, input logic [30:0] alim);
		write_reg(msi_pkg::CFG_VLIM, vlim);
		write_reg(msi_pkg::CFG_ALIM, alim);
	endtask

	// Mostly modest Q16.16 values, sometimes full range or the extremes.
	function automatic logic [31:0] rand_q();
		case ($urandom_range(7))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			2: return $urandom_range(2) - 1;
			default: return $urandom_range(32'h00ffffff) - 32'h00800000;
		endcase
	endfunction

	function automatic msi_pkg::req_t make_item(input logic [2:0] kind, input logic [15:0] dt);
		msi_pkg::req_t r;
		r.req_type = kind;
		r.set_pos = rand_q();
		r.set_vel = rand_q();
		r.set_acc = rand_q();
		r.set_torque = rand_q();
		r.meas_pos = rand_q();
		r.meas_vel = rand_q();
		r.step_time = dt;
		r.time_now = clock_q;
		return r;
	endfunction

	task automatic tick(input logic [15:0] dt);
		clock_q += dt;
		send_beat(make_item(msi_pkg::REQ_TICK, dt));
	endtask

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------
	// Every operation, unused codes, field extremes and saturating paths.
	task automatic test_directed();
		msi_pkg::req_t r;
		tick(16'd655);                         // torque mode out of reset
		r = make_item(msi_pkg::REQ_TORQUE, 0);
		r.set_torque = 32'h7fffffff;
		send_beat(r);
		tick(16'hffff);
		for (int k = msi_pkg::REQ_TICK + 1; k <= REQ_LAST; k++) begin
			send_beat(make_item(3'(k), 16'd100));  // dropped, no result
			tick(16'd0);
		end
		r = make_item(msi_pkg::REQ_VEL, 0);
		r.set_vel = 32'h80000000;
		r.meas_vel = 32'h7fffffff;
		send_beat(r);
		tick(16'hffff);
		tick(16'd0);
		r = make_item(msi_pkg::REQ_POS, 0);
		r.set_pos = 32'h7fffffff;
		send_beat(r);
		tick(16'hffff);
		tick(16'd1);
		r = make_item(msi_pkg::REQ_TRAJ, 0);
		r.set_pos = 32'h7fffffff;
		r.set_vel = 32'h7fffffff;
		r.set_acc = 32'h7fffffff;
		r.time_now = 32'hffffffff;
		send_beat(r);
		r = make_item(msi_pkg::REQ_TICK, 16'hffff);
		r.time_now = 32'hfffffffe;               // wraps to almost 2^16 seconds
		send_beat(r);
		r = make_item(msi_pkg::REQ_TRAJ, 0);
		r.set_pos = 32'h80000000;
		r.set_vel = 32'h80000000;
		r.set_acc = 32'h80000000;
		r.time_now = 32'h0;
		send_beat(r);
		r = make_item(msi_pkg::REQ_TICK, 16'd0);
		r.time_now = 32'h00ffffff;
		send_beat(r);
		r = make_item(msi_pkg::REQ_TORQUE, 0);
		r.set_torque = 32'h80000000;
		send_beat(r);
		tick(16'd1);
		drain();
	endtask

	// Position moves: goal then a run of ticks so the ramp brakes and cruises.
	task automatic run_position_move();
		send_beat(make_item(msi_pkg::REQ_POS, 0));
		repeat ($urandom_range(8, 30)) tick(16'($urandom_range(1) ? $urandom_range(16'h2000) :
			$urandom_range(16'hffff)));
	endtask

	task automatic run_velocity_slew();
		send_beat(make_item(msi_pkg::REQ_VEL, 0));
		repeat ($urandom_range(3, 12)) tick(16'($urandom_range(16'hffff)));
	endtask

	task automatic run_trajectory();
		send_beat(make_item(msi_pkg::REQ_TRAJ, 0));
		repeat ($urandom_range(2, 10)) begin
			if ($urandom_range(9) == 0) clock_q = $urandom;
			tick(16'($urandom_range(16'h4000)));
		end
	endtask

	// Loose beats in any order, unused codes now and then.
	task automatic run_noise();
		repeat ($urandom_range(2, 8))
			send_beat(make_item($urandom_range(9) == 0 ? 3'($urandom_range(5, 7)) :
				3'($urandom_range(4)), 16'($urandom)));
	endtask

	task automatic test_mixed(input int beats_wanted);
		for (int sent = 0; sent < beats_wanted; ) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin run_position_move(); sent += 20; end
				4, 5: begin run_velocity_slew(); sent += 8; end
				6, 7: begin run_trajectory(); sent += 7; end
				8: begin
					send_beat(make_item(msi_pkg::REQ_TORQUE, 0));
					tick(16'($urandom));
					sent += 2;
				end
				default: begin run_noise(); sent += 5; end
			endcase
		end
		drain();
	endtask

	// --------------------------------------------------------------------
	// Sequence
	// --------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = msi_pkg::CFG_VLIM;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		sh_mode = msi_pkg::MODE_TORQUE;
		{sh_sp_pos, sh_sp_vel, sh_goal_pos, sh_goal_vel} = '0;
		{sh_torque, sh_path_acc, sh_start_time} = '0;
		sh_vlim = LIM_ONE;
		sh_alim = LIM_ONE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();

		// no idling, slow limits
		set_limits(31'd1, 31'd1);
		test_mixed(470);

		// sender idles
		send_idle_pct = 54;
		set_limits(LIM_MAX, LIM_MAX);
		test_mixed(470);

		// receiver stalls
		send_idle_pct = 0;
		recv_stall_pct = 54;
		set_limits(LIM_ONE * 4, LIM_ONE / 2);
		test_mixed(470);

		// both sides idle now and then
		send_idle_pct = 9;
		recv_stall_pct = 9;
		set_limits(31'($urandom_range(1, LIM_MAX)), 31'($urandom_range(1, LIM_MAX)));
		test_mixed(470);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
